// ===== sv/fpau_pkg.sv =====
// Shared types, constants and operation codes for the fixed-point arithmetic unit.
// No dependencies; the files that use it refer to it by scoped names.
package fpau_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QW        = 32 + FRAC_BITS;   // quotient width of the divider

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_INC = 4'd10;
    localparam logic [3:0] OP_DEC = 4'd11;
    localparam logic [3:0] OP_MIN = 4'd12;
    localparam logic [3:0] OP_MAX = 4'd13;
    localparam logic [3:0] OP_INT = 4'd14;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DIV0 = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_flag;
        logic [1:0]         error_code;
    } t_out_word;

    typedef struct packed {
        logic [31:0]   rem;
        logic [QW-1:0] num;
        logic [31:0]   den;
        logic [QW-1:0] quo;
    } t_div;

    typedef struct packed {
        logic        valid;
        logic [3:0]  op;
        logic        neg;
        logic [31:0] res;
        logic        flag;
        logic [1:0]  err;
        logic [63:0] prod;
        t_div        div;
    } t_pipe;

endpackage

// ===== sv/fpau_front.sv =====
// Front end: input register, decode with the simple operations, and the multiplier.
// Depends on fpau_pkg.
module fpau_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  fpau_pkg::t_in_word i_word,
    output fpau_pkg::t_pipe   o_pipe
);

    logic               r_v0;
    fpau_pkg::t_in_word r_in;
    fpau_pkg::t_pipe    r_b, n_b, r_c, n_c;
    logic [31:0]        r_ma, r_mb, n_ma, n_mb;

    always_comb begin
        logic signed [32:0] sum, dif, inc, dec;
        logic signed [31:0] a, b;
        a = r_in.operand_a;
        b = r_in.operand_b;
        sum = 33'(a) + 33'(b);
        dif = 33'(a) - 33'(b);
        inc = 33'(a) + 33'sd1;
        dec = 33'(a) - 33'sd1;
        n_b = '0;
        n_b.valid = r_v0 && i_rst_n;
        n_b.op = r_in.operation;
        n_b.neg = a[31] ^ b[31];
        n_b.err = fpau_pkg::ERR_OK;
        n_ma = a[31] ? 32'(-a) : 32'(a);
        n_mb = b[31] ? 32'(-b) : 32'(b);
        unique case (r_in.operation)
            fpau_pkg::OP_ADD: begin
                n_b.res = sum[31:0];
                if (sum[32] != sum[31]) begin
                    n_b.res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_b.err = fpau_pkg::ERR_OVF;
                end
            end
            fpau_pkg::OP_SUB: begin
                n_b.res = dif[31:0];
                if (dif[32] != dif[31]) begin
                    n_b.res = dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    n_b.err = fpau_pkg::ERR_OVF;
                end
            end
            fpau_pkg::OP_INC: begin
                n_b.res = inc[31:0];
                if (inc[32] != inc[31]) begin
                    n_b.res = 32'h7FFF_FFFF;
                    n_b.err = fpau_pkg::ERR_OVF;
                end
            end
            fpau_pkg::OP_DEC: begin
                n_b.res = dec[31:0];
                if (dec[32] != dec[31]) begin
                    n_b.res = 32'h8000_0000;
                    n_b.err = fpau_pkg::ERR_OVF;
                end
            end
            fpau_pkg::OP_DIV: if (b == 32'sd0) n_b.err = fpau_pkg::ERR_DIV0;
            fpau_pkg::OP_GT:  n_b.flag = a > b;
            fpau_pkg::OP_LT:  n_b.flag = a < b;
            fpau_pkg::OP_GE:  n_b.flag = a >= b;
            fpau_pkg::OP_LE:  n_b.flag = a <= b;
            fpau_pkg::OP_EQ:  n_b.flag = a == b;
            fpau_pkg::OP_NE:  n_b.flag = a != b;
            fpau_pkg::OP_MIN: n_b.res = (a < b) ? a : b;
            fpau_pkg::OP_MAX: n_b.res = (a > b) ? a : b;
            fpau_pkg::OP_INT: n_b.res = a >>> fpau_pkg::FRAC_BITS;
            default: ;
        endcase
    end

    always_comb begin
        n_c = r_b;
        n_c.valid = r_b.valid && i_rst_n;
        n_c.prod = 64'(r_ma) * 64'(r_mb);
        n_c.div.rem = '0;
        n_c.div.num = {r_ma, fpau_pkg::FRAC_BITS'(0)};
        n_c.div.den = r_mb;
        n_c.div.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_in <= i_word;
            r_ma <= n_ma;
            r_mb <= n_mb;
        end
        // valid bits drop to zero in reset through the next-value logic
        if (!i_rst_n || i_en) begin
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_pipe = r_c;

endmodule

// ===== sv/fpau_div_stage.sv =====
// One step of the restoring divider: one quotient bit per stage.
// Depends on fpau_pkg.
module fpau_div_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpau_pkg::t_pipe i_pipe,
    output fpau_pkg::t_pipe o_pipe
);

    fpau_pkg::t_pipe r_p, n_p;

    always_comb begin
        logic [32:0] t;
        logic        ge;
        t  = {i_pipe.div.rem, i_pipe.div.num[fpau_pkg::QW-1]};
        ge = t >= {1'b0, i_pipe.div.den};
        n_p = i_pipe;
        n_p.valid = i_pipe.valid && i_rst_n;
        n_p.div.rem = ge ? 32'(t - {1'b0, i_pipe.div.den}) : t[31:0];
        n_p.div.num = {i_pipe.div.num[fpau_pkg::QW-2:0], 1'b0};
        n_p.div.quo = {i_pipe.div.quo[fpau_pkg::QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_en) r_p <= n_p;
    end

    assign o_pipe = r_p;

endmodule

// ===== sv/fpau_back.sv =====
// Back end: rounding of product and quotient, then saturation into the output register.
// Depends on fpau_pkg.
module fpau_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fpau_pkg::t_pipe    i_pipe,
    output logic               o_valid,
    output fpau_pkg::t_out_word o_word
);

    logic               r_nv, r_neg, r_arith, r_valid;
    logic [31:0]        r_res;
    logic               r_flag;
    logic [1:0]         r_err;
    logic [63:0]        r_n, n_n;
    fpau_pkg::t_out_word r_out, n_out;

    always_comb begin
        logic rnd;
        rnd = {i_pipe.div.rem, 1'b0} >= {1'b0, i_pipe.div.den};
        if (i_pipe.op == fpau_pkg::OP_MUL)
            n_n = (i_pipe.prod + (64'd1 << (fpau_pkg::FRAC_BITS - 1)))
                  >> fpau_pkg::FRAC_BITS;
        else
            n_n = 64'(i_pipe.div.quo) + 64'(rnd);
    end

    always_comb begin
        n_out.result_value = r_res;
        n_out.compare_flag = r_flag;
        n_out.error_code   = r_err;
        if (r_arith) begin
            if (r_neg) begin
                if (r_n > 64'h8000_0000) begin
                    n_out.result_value = 32'h8000_0000;
                    n_out.error_code   = fpau_pkg::ERR_OVF;
                end else begin
                    n_out.result_value = 32'(-r_n[31:0]);
                end
            end else if (r_n > 64'h7FFF_FFFF) begin
                n_out.result_value = 32'h7FFF_FFFF;
                n_out.error_code   = fpau_pkg::ERR_OVF;
            end else begin
                n_out.result_value = r_n[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_nv    <= i_pipe.valid;
            r_valid <= r_nv;
        end
        if (i_en) begin
            r_n     <= n_n;
            r_neg   <= i_pipe.neg;
            r_res   <= i_pipe.res;
            r_flag  <= i_pipe.flag;
            r_err   <= i_pipe.err;
            r_arith <= (i_pipe.op == fpau_pkg::OP_MUL)
                    || (i_pipe.op == fpau_pkg::OP_DIV && i_pipe.err == fpau_pkg::ERR_OK);
            r_out   <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

// ===== sv/fpau_top_unused.sv =====
// Small stall controller for the unit: one global advance enable from the output side.
// No dependencies.
module fpau_stall_ctl (
    input  logic i_out_valid,
    input  logic i_stall,
    output logic o_en
);

    // advance unless a finished word waits on a stalled consumer
    assign o_en = !(i_out_valid && i_stall);

endmodule

// ===== sv/fixed_point_arithmetic_unit_core.sv =====
// Q24.8 fixed-point arithmetic unit. Pipeline stages in order:
// input register, decode, multiply, one restoring-divider stage per quotient bit,
// rounding, saturation/output register. Throughput one word per cycle; the whole
// pipeline holds while a result waits on a stalled consumer.
// Synchronous active-low reset clears every valid bit; payload registers are not reset.
// Depends on fpau_pkg, fpau_front, fpau_div_stage, fpau_back, fpau_stall_ctl.
module fixed_point_arithmetic_unit_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fpau_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output fpau_pkg::t_out_word o_word
);

    logic            en;
    fpau_pkg::t_pipe pipe [0:fpau_pkg::QW];

    // one enable for every stage: advance everything or hold everything
    fpau_stall_ctl u_ctl (
        .i_out_valid (o_valid),
        .i_stall     (i_stall),
        .o_en        (en)
    );

    assign o_stall = !en;

    // decode, simple operations and the multiplier
    fpau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_pipe  (pipe[0])
    );

    // divider chain: one quotient bit per stage, every word passes through
    for (genvar g = 0; g < fpau_pkg::QW; g++) begin : g_div
        fpau_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_pipe  (pipe[g]),
            .o_pipe  (pipe[g+1])
        );
    end

    // round half away from zero, saturate, hold the word for the consumer
    fpau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_pipe  (pipe[fpau_pkg::QW]),
        .o_valid (o_valid),
        .o_word  (o_word)
    );

endmodule

// ===== sim/fixed_point_arithmetic_unit_core_test.sv =====
// Self-checking bench for the fixed-point arithmetic unit core.
// Drives operation words, predicts each result in a scoreboard class and compares in order.
// Depends on fpau_pkg and fixed_point_arithmetic_unit_core.
module fixed_point_arithmetic_unit_core_test;

    // Pipeline depth of the core: its registered stages from input to output.
    localparam int PIPE_DEPTH = fpau_pkg::QW + 5;
    localparam int N_RANDOM   = 500;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    fpau_pkg::t_in_word  i_word;
    logic                o_valid;
    logic                i_stall;
    fpau_pkg::t_out_word o_word;

    int error_count;
    bit stim_done;
    bit quiet_phase;   // no idling on either side in the last part of the run
    bit hold_recv;     // long receiver hold-off to fill the pipeline

    fixed_point_arithmetic_unit_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Predicts results and holds the expected words in acceptance order.
    class alu_scoreboard;
        fpau_pkg::t_out_word pending[$];

        // Saturate a wide signed value to 32 bits.
        function automatic void saturate(input logic signed [65:0] v,
                                         ref fpau_pkg::t_out_word w);
            if (v > 66'sd2147483647) begin
                w.result_value = 32'h7FFF_FFFF;
                w.error_code   = fpau_pkg::ERR_OVF;
            end else if (v < -66'sd2147483648) begin
                w.result_value = 32'h8000_0000;
                w.error_code   = fpau_pkg::ERR_OVF;
            end else begin
                w.result_value = v[31:0];
            end
        endfunction

        // Apply sign to a rounded magnitude, saturating.
        function automatic void signed_mag(input bit neg, input logic [65:0] mag,
                                           ref fpau_pkg::t_out_word w);
            logic signed [66:0] v;
            v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            saturate(v[65:0], w);
        endfunction

        function automatic fpau_pkg::t_out_word compute(input fpau_pkg::t_in_word x);
            fpau_pkg::t_out_word w;
            logic signed [65:0] a, b;
            logic [65:0] ma, mb, n;
            bit neg;
            w = '0;
            a = x.operand_a;
            b = x.operand_b;
            ma = a < 0 ? -a : a;
            mb = b < 0 ? -b : b;
            neg = (a < 0) != (b < 0);
            case (x.operation)
                fpau_pkg::OP_ADD: saturate(a + b, w);
                fpau_pkg::OP_SUB: saturate(a - b, w);
                fpau_pkg::OP_MUL: begin
                    n = (ma * mb + (66'd1 << (fpau_pkg::FRAC_BITS - 1)))
                        >> fpau_pkg::FRAC_BITS;
                    signed_mag(neg, n, w);
                end
                fpau_pkg::OP_DIV: begin
                    if (b == 0) begin
                        w.error_code = fpau_pkg::ERR_DIV0;
                    end else begin
                        n = (2 * (ma << fpau_pkg::FRAC_BITS) + mb) / (2 * mb);
                        signed_mag(neg, n, w);
                    end
                end
                fpau_pkg::OP_GT:  w.compare_flag = a > b;
                fpau_pkg::OP_LT:  w.compare_flag = a < b;
                fpau_pkg::OP_GE:  w.compare_flag = a >= b;
                fpau_pkg::OP_LE:  w.compare_flag = a <= b;
                fpau_pkg::OP_EQ:  w.compare_flag = a == b;
                fpau_pkg::OP_NE:  w.compare_flag = a != b;
                fpau_pkg::OP_INC: saturate(a + 1, w);
                fpau_pkg::OP_DEC: saturate(a - 1, w);
                fpau_pkg::OP_MIN: w.result_value = (a < b) ? x.operand_a : x.operand_b;
                fpau_pkg::OP_MAX: w.result_value = (a > b) ? x.operand_a : x.operand_b;
                fpau_pkg::OP_INT: w.result_value = x.operand_a >>> fpau_pkg::FRAC_BITS;
                default: ;
            endcase
            return w;
        endfunction

        function void note_input(input fpau_pkg::t_in_word x);
            pending.push_back(compute(x));
        endfunction

        task check_result(input fpau_pkg::t_out_word got);
            fpau_pkg::t_out_word want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", longint'(got), 0);
                return;
            end
            want = pending.pop_front();
            if (got.result_value !== want.result_value)
                report_mismatch("result_value", got.result_value, want.result_value);
            if (got.compare_flag !== want.compare_flag)
                report_mismatch("compare_flag", got.compare_flag, want.compare_flag);
            if (got.error_code !== want.error_code)
                report_mismatch("error_code", got.error_code, want.error_code);
        endtask
    endclass

    alu_scoreboard board;

    always #2 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                board.note_input(i_word);
            if (o_valid && !i_stall)
                board.check_result(o_word);
        end
    end

    // Offer one word and hold it until accepted; idle in bursts beforehand.
    task automatic send_word(input fpau_pkg::t_in_word x);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= x;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Bias operands towards edges so saturation and rounding get exercised.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 600) - 300;
            3: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic fpau_pkg::t_in_word make_word(input logic [3:0] op,
                                                     input logic [31:0] a,
                                                     input logic [31:0] b);
        fpau_pkg::t_in_word x;
        x.operation = op;
        x.operand_a = a;
        x.operand_b = b;
        return x;
    endfunction

    // Receiver: stall in random bursts, once for a long stretch, none at the end.
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_recv) begin
                i_stall <= 1'b1;
                repeat (PIPE_DEPTH * 3) @(negedge i_clk);
                i_stall <= 1'b0;
                hold_recv = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 11);
                i_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus: directed corners, then random words, then drain.
    initial begin
        logic [31:0] corner_a[6];
        logic [31:0] corner_b[6];
        int waited;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_word      = '0;
        error_count = 0;
        stim_done   = 1'b0;
        quiet_phase = 1'b0;
        hold_recv   = 1'b0;
        board       = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Every operation at extreme operands: saturation, rounding, ties.
        corner_a = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0180, 32'hFFFF_FE80, 32'h0, 32'h1};
        corner_b = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0080, 32'h0000_0200, 32'h0,
                     32'hFFFF_FFFF};
        for (int op = 0; op < 16; op++)
            send_word(make_word(op[3:0], corner_a[op % 6], corner_b[(op + 1) % 6]));
        send_word(make_word(fpau_pkg::OP_DIV, 32'h0000_0500, 32'h0));  // division by zero
        send_word(make_word(fpau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000)); // product overflow
        send_word(make_word(fpau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001)); // quotient ovf
        send_word(make_word(fpau_pkg::OP_INC, 32'h7FFF_FFFF, 32'h0));
        send_word(make_word(fpau_pkg::OP_DEC, 32'h8000_0000, 32'h0));
        send_word(make_word(fpau_pkg::OP_MIN, 32'h0000_1234, 32'h0000_1234)); // tie returns b
        send_word(make_word(fpau_pkg::OP_MUL, 32'hFFFF_FF80, 32'h0000_0001)); // half away
        send_word(make_word(fpau_pkg::OP_INT, 32'hFFFF_FFFF, 32'h0));

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 150)
                hold_recv = 1'b1;   // sender keeps offering while the output holds off
            if (i == N_RANDOM - 80)
                quiet_phase = 1'b1;
            send_word(make_word(4'($urandom_range(0, 15)), pick_operand(), pick_operand()));
        end
        i_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 10) @(negedge i_clk);
        if (error_count == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/fpau_pkg.sv
sv/fpau_front.sv
sv/fpau_div_stage.sv
sv/fpau_back.sv
sv/fpau_top_unused.sv
sv/fixed_point_arithmetic_unit_core.sv
sim/fixed_point_arithmetic_unit_core_test.sv
